// ===== rtl/core/ept_pkg.sv =====
// ----------------------------------------------------------------------------
// ept_pkg
// Shared constants and helpers for the pose-to-homogeneous-transform pipeline.
// ----------------------------------------------------------------------------
package ept_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ROT_FRAC_BITS_DEF = 14;
  localparam int TBL_LEN           = 24;

  localparam int TRANS_W = 20;
  localparam int ANG_W   = 16;
  localparam int ROT_W   = 16;
  localparam int POS_W   = 30;
  localparam int Z_W     = 21;  // Q.16 angle, reduced
  localparam int XY_W    = 33;  // CORDIC datapath, Q.30 plus headroom
  localparam int CS_W    = 32;  // cos/sin and products, Q.30

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [Z_W-1:0]  PI_Q16      = 21'sd205887;
  localparam logic signed [Z_W-1:0]  HALF_PI_Q16 = 21'sd102944;
  localparam logic signed [10:0]     MM_PER_M    = 11'sd1000;

  typedef logic signed [CS_W-1:0] cs_t;

  // Q.16 arctangent of 2^-i
  function automatic logic signed [Z_W-1:0] atan_q16(input int idx);
    logic signed [Z_W-1:0] t;
    begin
      unique case (idx)
        0:  t = 21'sd51472;
        1:  t = 21'sd30386;
        2:  t = 21'sd16055;
        3:  t = 21'sd8150;
        4:  t = 21'sd4091;
        5:  t = 21'sd2047;
        6:  t = 21'sd1024;
        7:  t = 21'sd512;
        8:  t = 21'sd256;
        9:  t = 21'sd128;
        10: t = 21'sd64;
        11: t = 21'sd32;
        12: t = 21'sd16;
        13: t = 21'sd8;
        14: t = 21'sd4;
        15: t = 21'sd2;
        16: t = 21'sd1;
        default: t = '0;
      endcase
      return t;
    end
  endfunction

  // Q.30 by Q.30 product, rounded half up back to Q.30
  function automatic cs_t qmul(input cs_t a, input cs_t b);
    logic signed [63:0] p;
    begin
      p = 64'(a) * 64'(b) + (64'sd1 <<< 29);
      return p[61:30];
    end
  endfunction

endpackage

// ===== rtl/core/ept_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// ept_cordic_cell
// One rotation-mode CORDIC micro-rotation with its own pipeline register.
// ----------------------------------------------------------------------------
module ept_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [ept_pkg::XY_W-1:0] x_i,
  input  logic signed [ept_pkg::XY_W-1:0] y_i,
  input  logic signed [ept_pkg::Z_W-1:0]  z_i,
  input  logic                            neg_i,
  output logic signed [ept_pkg::XY_W-1:0] x_o,
  output logic signed [ept_pkg::XY_W-1:0] y_o,
  output logic signed [ept_pkg::Z_W-1:0]  z_o,
  output logic                            neg_o
);
  import ept_pkg::*;

  localparam logic signed [Z_W-1:0] ATAN = atan_q16(STAGE);

  logic signed [XY_W-1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [Z_W-1:0]  z_r, z_nxt;
  logic                   neg_r;

  always_comb begin
    if (z_i >= 0) begin
      x_nxt = x_i - (y_i >>> STAGE);
      y_nxt = y_i + (x_i >>> STAGE);
      z_nxt = z_i - ATAN;
    end else begin
      x_nxt = x_i + (y_i >>> STAGE);
      y_nxt = y_i - (x_i >>> STAGE);
      z_nxt = z_i + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
      neg_r <= neg_i;
    end
  end

  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;
  assign neg_o = neg_r;

endmodule

// ===== rtl/core/ept_cordic.sv =====
// ----------------------------------------------------------------------------
// ept_cordic
// Quadrant fold, chain of CORDIC cells and sign fix: cosine and sine in Q.30.
// ----------------------------------------------------------------------------
module ept_cordic #(
  parameter int NS = ept_pkg::CORDIC_STAGES_DEF
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [ept_pkg::ANG_W-1:0] ang_i,
  output ept_pkg::cs_t                     cos_o,
  output ept_pkg::cs_t                     sin_o
);
  import ept_pkg::*;

  logic signed [Z_W-1:0]  z_in, z_fold;
  logic                   neg_fold;
  logic signed [Z_W-1:0]  z_r;
  logic                   neg_r;
  logic signed [XY_W-1:0] xs [NS+1];
  logic signed [XY_W-1:0] ys [NS+1];
  logic signed [Z_W-1:0]  zs [NS+1];
  logic                   ns [NS+1];
  cs_t                    cos_r, sin_r;

  // fold angles beyond a quarter turn back by pi
  always_comb begin
    z_in = Z_W'(ang_i) <<< 3;
    priority if (z_in > HALF_PI_Q16) begin
      z_fold   = z_in - PI_Q16;
      neg_fold = 1'b1;
    end else if (z_in < -HALF_PI_Q16) begin
      z_fold   = z_in + PI_Q16;
      neg_fold = 1'b1;
    end else begin
      z_fold   = z_in;
      neg_fold = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_r   <= z_fold;
      neg_r <= neg_fold;
    end
  end

  assign xs[0] = CORDIC_GAIN;
  assign ys[0] = '0;
  assign zs[0] = z_r;
  assign ns[0] = neg_r;

  for (genvar i = 0; i < NS; i++) begin : g_cell
    ept_cordic_cell #(.STAGE(i)) u_cell (
      .clk   (clk),
      .en    (en),
      .x_i   (xs[i]),
      .y_i   (ys[i]),
      .z_i   (zs[i]),
      .neg_i (ns[i]),
      .x_o   (xs[i+1]),
      .y_o   (ys[i+1]),
      .z_o   (zs[i+1]),
      .neg_o (ns[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= ns[NS] ? CS_W'(-xs[NS]) : CS_W'(xs[NS]);
      sin_r <= ns[NS] ? CS_W'(-ys[NS]) : CS_W'(ys[NS]);
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

// ===== rtl/core/ept_rot.sv =====
// ----------------------------------------------------------------------------
// ept_rot
// Three-stage product pipeline forming the saturated ZYX rotation entries.
// ----------------------------------------------------------------------------
module ept_rot #(
  parameter int ROT_FRAC_BITS = ept_pkg::ROT_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  ept_pkg::cs_t         ca,
  input  ept_pkg::cs_t         sa,
  input  ept_pkg::cs_t         cb,
  input  ept_pkg::cs_t         sb,
  input  ept_pkg::cs_t         cc,
  input  ept_pkg::cs_t         sc,
  output logic signed [ept_pkg::ROT_W-1:0] rot_o [9]
);
  import ept_pkg::*;

  localparam int SH = 30 - ROT_FRAC_BITS;
  localparam logic signed [35:0] HALF = (SH > 0) ? (36'sd1 <<< ((SH > 0) ? SH - 1 : 0)) : '0;
  localparam logic signed [35:0] ONE  = 36'sd1 <<< ROT_FRAC_BITS;

  function automatic logic signed [ROT_W-1:0] rot_out(input logic signed [33:0] v);
    logic signed [35:0] r;
    begin
      r = (36'(v) + HALF) >>> SH;
      if (r > ONE)  r = ONE;
      if (r < -ONE) r = -ONE;
      return r[ROT_W-1:0];
    end
  endfunction

  // stage A: two-factor products
  cs_t casb_r, sasb_r, cacb_r, sacc_r, sasc_r, sacb_r, cacc_r, casc_r, cbsc_r, cbcc_r;
  cs_t sba_r, cca_r, sca_r;
  // stage B: three-factor products
  cs_t p01_r, p02_r, p11_r, p12_r;
  cs_t sacc_b_r, sasc_b_r, cacc_b_r, casc_b_r, cacb_b_r, sacb_b_r, cbsc_b_r, cbcc_b_r, sb_b_r;
  logic signed [ROT_W-1:0] rot_r [9];

  always_ff @(posedge clk) begin
    if (en) begin
      casb_r <= qmul(ca, sb);
      sasb_r <= qmul(sa, sb);
      cacb_r <= qmul(ca, cb);
      sacc_r <= qmul(sa, cc);
      sasc_r <= qmul(sa, sc);
      sacb_r <= qmul(sa, cb);
      cacc_r <= qmul(ca, cc);
      casc_r <= qmul(ca, sc);
      cbsc_r <= qmul(cb, sc);
      cbcc_r <= qmul(cb, cc);
      sba_r  <= sb;
      cca_r  <= cc;
      sca_r  <= sc;

      p01_r    <= qmul(casb_r, sca_r);
      p02_r    <= qmul(casb_r, cca_r);
      p11_r    <= qmul(sasb_r, sca_r);
      p12_r    <= qmul(sasb_r, cca_r);
      sacc_b_r <= sacc_r;
      sasc_b_r <= sasc_r;
      cacc_b_r <= cacc_r;
      casc_b_r <= casc_r;
      cacb_b_r <= cacb_r;
      sacb_b_r <= sacb_r;
      cbsc_b_r <= cbsc_r;
      cbcc_b_r <= cbcc_r;
      sb_b_r   <= sba_r;

      rot_r[0] <= rot_out(34'(cacb_b_r));
      rot_r[1] <= rot_out(34'(p01_r) - 34'(sacc_b_r));
      rot_r[2] <= rot_out(34'(p02_r) + 34'(sasc_b_r));
      rot_r[3] <= rot_out(34'(sacb_b_r));
      rot_r[4] <= rot_out(34'(p11_r) + 34'(cacc_b_r));
      rot_r[5] <= rot_out(34'(p12_r) - 34'(casc_b_r));
      rot_r[6] <= rot_out(-34'(sb_b_r));
      rot_r[7] <= rot_out(34'(cbsc_b_r));
      rot_r[8] <= rot_out(34'(cbcc_b_r));
    end
  end

  assign rot_o = rot_r;

endmodule

// ===== rtl/core/euler_pose_to_homogeneous_top.sv =====
// ----------------------------------------------------------------------------
// euler_pose_to_homogeneous_top
// Tool pose (translation, roll/pitch/yaw) to top three rows of its transform.
// ----------------------------------------------------------------------------
//  channel | signals                              | word
//  in      | in_valid, in_ready, in_trans_*, in_*_angle | one pose
//  out     | out_valid, out_ready, out_rot_*, out_pos_* | one transform
//
//  One word per cycle while the output is not stalled. The pipeline registers are
//  angle fold, one cell per CORDIC stage (CORDIC_STAGES, capped at 24), sign
//  fix, two product stages and the rounding/saturating output register.
//  rst_n (synchronous, active low) clears the valid line; data needs none.
//  A result held at the output with out_ready low freezes the whole pipe,
//  so in_ready drops only then.
// ----------------------------------------------------------------------------
module euler_pose_to_homogeneous_top #(
  parameter int CORDIC_STAGES = ept_pkg::CORDIC_STAGES_DEF,
  parameter int ROT_FRAC_BITS = ept_pkg::ROT_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [ept_pkg::TRANS_W-1:0] in_trans_x_m,
  input  logic signed [ept_pkg::TRANS_W-1:0] in_trans_y_m,
  input  logic signed [ept_pkg::TRANS_W-1:0] in_trans_z_m,
  input  logic signed [ept_pkg::ANG_W-1:0]   in_roll_angle,
  input  logic signed [ept_pkg::ANG_W-1:0]   in_pitch_angle,
  input  logic signed [ept_pkg::ANG_W-1:0]   in_yaw_angle,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [ept_pkg::ROT_W-1:0] out_rot_r0c0,
  output logic signed [ept_pkg::ROT_W-1:0] out_rot_r0c1,
  output logic signed [ept_pkg::ROT_W-1:0] out_rot_r0c2,
  output logic signed [ept_pkg::ROT_W-1:0] out_rot_r1c0,
  output logic signed [ept_pkg::ROT_W-1:0] out_rot_r1c1,
  output logic signed [ept_pkg::ROT_W-1:0] out_rot_r1c2,
  output logic signed [ept_pkg::ROT_W-1:0] out_rot_r2c0,
  output logic signed [ept_pkg::ROT_W-1:0] out_rot_r2c1,
  output logic signed [ept_pkg::ROT_W-1:0] out_rot_r2c2,
  output logic signed [ept_pkg::POS_W-1:0] out_pos_x_mm,
  output logic signed [ept_pkg::POS_W-1:0] out_pos_y_mm,
  output logic signed [ept_pkg::POS_W-1:0] out_pos_z_mm
);
  import ept_pkg::*;

  // stages beyond the table only add zero-angle rotations; stop at its end
  localparam int NS  = (CORDIC_STAGES > TBL_LEN) ? TBL_LEN : CORDIC_STAGES;
  localparam int LAT = NS + 5;

  logic en;
  logic [LAT-1:0] vld_r;
  cs_t ca, sa, cb, sb, cc, sc;
  logic signed [ROT_W-1:0] rot [9];
  logic signed [POS_W-1:0] px_r [LAT];
  logic signed [POS_W-1:0] py_r [LAT];
  logic signed [POS_W-1:0] pz_r [LAT];

  // advance everything unless the output word is stuck
  assign en       = !vld_r[LAT-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  ept_cordic #(.NS(NS)) u_roll (
    .clk(clk), .en(en), .ang_i(in_roll_angle), .cos_o(cc), .sin_o(sc));
  ept_cordic #(.NS(NS)) u_pitch (
    .clk(clk), .en(en), .ang_i(in_pitch_angle), .cos_o(cb), .sin_o(sb));
  ept_cordic #(.NS(NS)) u_yaw (
    .clk(clk), .en(en), .ang_i(in_yaw_angle), .cos_o(ca), .sin_o(sa));

  ept_rot #(.ROT_FRAC_BITS(ROT_FRAC_BITS)) u_rot (
    .clk(clk), .en(en),
    .ca(ca), .sa(sa), .cb(cb), .sb(sb), .cc(cc), .sc(sc),
    .rot_o(rot)
  );

  // scale metres to millimetres up front, then delay alongside the rotation
  always_ff @(posedge clk) begin
    if (en) begin
      px_r[0] <= POS_W'(31'(in_trans_x_m) * 31'(MM_PER_M));
      py_r[0] <= POS_W'(31'(in_trans_y_m) * 31'(MM_PER_M));
      pz_r[0] <= POS_W'(31'(in_trans_z_m) * 31'(MM_PER_M));
      for (int i = 1; i < LAT; i++) begin
        px_r[i] <= px_r[i-1];
        py_r[i] <= py_r[i-1];
        pz_r[i] <= pz_r[i-1];
      end
    end
  end

  assign out_valid    = vld_r[LAT-1];
  assign out_rot_r0c0 = rot[0];
  assign out_rot_r0c1 = rot[1];
  assign out_rot_r0c2 = rot[2];
  assign out_rot_r1c0 = rot[3];
  assign out_rot_r1c1 = rot[4];
  assign out_rot_r1c2 = rot[5];
  assign out_rot_r2c0 = rot[6];
  assign out_rot_r2c1 = rot[7];
  assign out_rot_r2c2 = rot[8];
  assign out_pos_x_mm = px_r[LAT-1];
  assign out_pos_y_mm = py_r[LAT-1];
  assign out_pos_z_mm = pz_r[LAT-1];

endmodule

// ===== dv/tb_euler_pose_to_homogeneous_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_euler_pose_to_homogeneous_top
// Sends tool poses with random gaps and output stalls, computes each expected
// transform with a local CORDIC and product model, and checks every word.
// ----------------------------------------------------------------------------
module tb_euler_pose_to_homogeneous_top;
  import ept_pkg::*;

  localparam int STAGES    = CORDIC_STAGES_DEF;
  localparam int FRAC      = ROT_FRAC_BITS_DEF;
  localparam int LATENCY   = STAGES + 5;
  localparam int MAX_CYCLES = 400000;

  typedef struct packed {
    logic signed [TRANS_W-1:0] tx, ty, tz;
    logic signed [ANG_W-1:0]   roll, pitch, yaw;
  } pose_t;

  typedef struct packed {
    logic signed [ROT_W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    logic signed [POS_W-1:0] px, py, pz;
  } xform_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  pose_t drv;
  xform_t got;

  xform_t xform_q[$];
  int     n_sent, n_checked, n_bad, cycle;
  bit     hold_off_req;   // long output stall requested

  euler_pose_to_homogeneous_top u_top (
    .clk, .rst_n,
    .in_valid, .in_ready,
    .in_trans_x_m(drv.tx), .in_trans_y_m(drv.ty), .in_trans_z_m(drv.tz),
    .in_roll_angle(drv.roll), .in_pitch_angle(drv.pitch), .in_yaw_angle(drv.yaw),
    .out_valid, .out_ready,
    .out_rot_r0c0(got.r00), .out_rot_r0c1(got.r01), .out_rot_r0c2(got.r02),
    .out_rot_r1c0(got.r10), .out_rot_r1c1(got.r11), .out_rot_r1c2(got.r12),
    .out_rot_r2c0(got.r20), .out_rot_r2c1(got.r21), .out_rot_r2c2(got.r22),
    .out_pos_x_mm(got.px), .out_pos_y_mm(got.py), .out_pos_z_mm(got.pz)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- model
  // Arctangent of 2^-i in Q.16.
  function automatic longint arctan_step(int i);
    longint tab[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                        256, 128, 64, 32, 16, 8, 4, 2, 1};
    if (i < 17) return tab[i];
    return 0;
  endfunction

  // Round half up, then floor shift (>>> on longint is a floor shift).
  function automatic longint round_down(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return round_down(a * b, 30);
  endfunction

  // Cosine and sine of a Q3.13 angle, Q.30, with half-turn folding.
  task automatic sincos(input logic signed [ANG_W-1:0] ang,
                        output longint c, output longint s);
    longint z, x, y, nx;
    bit flip;
    z = longint'(ang) * 8;
    x = 652032874;
    y = 0;
    flip = 0;
    if (z > 102944) begin
      z -= 205887; flip = 1;
    end else if (z < -102944) begin
      z += 205887; flip = 1;
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= arctan_step(i);
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += arctan_step(i);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic logic signed [ROT_W-1:0] rot_entry(longint v);
    longint one, r;
    one = longint'(1) <<< FRAC;
    r = round_down(v, 30 - FRAC);
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r[ROT_W-1:0];
  endfunction

  function automatic logic signed [POS_W-1:0] to_mm(logic signed [TRANS_W-1:0] m);
    longint p;
    p = longint'(m) * 1000;
    return p[POS_W-1:0];
  endfunction

  task automatic predict_xform(input pose_t p, output xform_t t);
    longint ca, sa, cb, sb, cc, sc, casb, sasb;
    sincos(p.roll, cc, sc);
    sincos(p.pitch, cb, sb);
    sincos(p.yaw, ca, sa);
    casb = fx_mul(ca, sb);
    sasb = fx_mul(sa, sb);
    t.r00 = rot_entry(fx_mul(ca, cb));
    t.r01 = rot_entry(fx_mul(casb, sc) - fx_mul(sa, cc));
    t.r02 = rot_entry(fx_mul(casb, cc) + fx_mul(sa, sc));
    t.r10 = rot_entry(fx_mul(sa, cb));
    t.r11 = rot_entry(fx_mul(sasb, sc) + fx_mul(ca, cc));
    t.r12 = rot_entry(fx_mul(sasb, cc) - fx_mul(ca, sc));
    t.r20 = rot_entry(-sb);
    t.r21 = rot_entry(fx_mul(cb, sc));
    t.r22 = rot_entry(fx_mul(cb, cc));
    t.px = to_mm(p.tx);
    t.py = to_mm(p.ty);
    t.pz = to_mm(p.tz);
  endtask

  // ---------------------------------------------------------------- gaps
  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------- driver
  // Offer one word and hold it until accepted; predict at acceptance.
  // Leave valid up afterward so the next word can follow with no gap.
  task automatic send_pose(input pose_t p, input bit gap_ok);
    xform_t t;
    int g;
    g = gap_ok ? pick_gap() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    drv <= p;
    do @(posedge clk); while (!in_ready);
    predict_xform(p, t);
    xform_q.insert(xform_q.size(), t);
    n_sent++;
  endtask

  // Drop valid and let a clock edge pass before waiting on results.
  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [ANG_W-1:0] rand_angle();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return ANG_W'($urandom());           // full code range
    if (r == 1) return ANG_W'($urandom_range(0, 1000) - 500); // near zero
    return ANG_W'(int'($urandom_range(0, 51472)) - 25736);
  endfunction

  function automatic pose_t rand_pose();
    pose_t p;
    p.tx = TRANS_W'($urandom());
    p.ty = TRANS_W'($urandom());
    p.tz = TRANS_W'($urandom());
    p.roll = rand_angle();
    p.pitch = rand_angle();
    p.yaw = rand_angle();
    return p;
  endfunction

  task automatic wait_drained();
    while (xform_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- tests
  // Field extremes, quarter and half turns, and codes past +-pi.
  task automatic test_directed();
    logic signed [ANG_W-1:0] angs[12] = '{16'sd0, 16'sd25736, -16'sd25736,
      16'sd12868, 16'sd12869, -16'sd12868, -16'sd12869, 16'sd32767,
      -16'sd32768, 16'sd1, -16'sd1, 16'sd6434};
    pose_t p;
    for (int i = 0; i < 12; i++) begin
      p.tx = (i % 3 == 0) ? 20'sh7FFFF : (i % 3 == 1) ? 20'sh80000 : '0;
      p.ty = (i % 2 == 0) ? 20'sh80000 : 20'sh7FFFF;
      p.tz = (i % 2 == 0) ? -20'sd1 : 20'sd1;
      p.roll = angs[i];
      p.pitch = angs[(i + 4) % 12];
      p.yaw = angs[(i + 8) % 12];
      send_pose(p, 1'b1);
    end
    // Each angle alone at each extreme.
    for (int i = 0; i < 6; i++) begin
      p = '0;
      if (i < 2) p.roll = i[0] ? 16'sd25736 : -16'sd32768;
      else if (i < 4) p.pitch = i[0] ? 16'sd32767 : -16'sd25736;
      else p.yaw = i[0] ? -16'sd25736 : 16'sd25736;
      send_pose(p, 1'b0);
    end
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_pose(rand_pose(), 1'b1);
  endtask

  // Stall the output for a long stretch while words keep coming: fills the pipe.
  task automatic test_backpressure();
    hold_off_req = 1'b1;
    for (int i = 0; i < 60; i++) send_pose(rand_pose(), 1'b0);
    idle_input();
    wait (hold_off_req == 1'b0);
    wait_drained();   // sender pauses until every result is back
  endtask

  // ---------------------------------------------------------------- sink
  // Drive out_ready: random stalls, or a long hold-off when requested.
  initial begin
    int g;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_off_req = 1'b0;
      end
      g = pick_gap();
      if (cycle % 3000 < 600) g = 0;   // stretches with no stalling
      out_ready <= (g == 0);
      @(posedge clk);
      if (g > 1) repeat (g - 1) @(posedge clk);
    end
  end

  // Compare each accepted word with the oldest expectation.
  always @(posedge clk) begin
    xform_t e;
    if (rst_n && out_valid && out_ready) begin
      if (xform_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected transform word at cycle %0d", cycle);
      end else begin
        e = xform_q.pop_front();
        n_checked++;
        if (got !== e) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("mismatch on word %0d:", n_checked - 1);
            $display("  rot exp %0d %0d %0d %0d %0d %0d %0d %0d %0d", e.r00, e.r01,
                     e.r02, e.r10, e.r11, e.r12, e.r20, e.r21, e.r22);
            $display("  rot got %0d %0d %0d %0d %0d %0d %0d %0d %0d", got.r00,
                     got.r01, got.r02, got.r10, got.r11, got.r12, got.r20,
                     got.r21, got.r22);
            $display("  pos exp %0d %0d %0d got %0d %0d %0d", e.px, e.py, e.pz,
                     got.px, got.py, got.pz);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle == MAX_CYCLES) begin
      $display("timeout with %0d words outstanding", xform_q.size());
      $display("[euler_pose_to_homogeneous_top] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- main
  initial begin
    cycle = 0;
    n_sent = 0;
    n_checked = 0;
    n_bad = 0;
    hold_off_req = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    drv = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(200);
    test_backpressure();
    test_random(190);

    idle_input();
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);

    $display("sent %0d poses (directed extremes, folded angles, random), checked %0d",
             n_sent, n_checked);
    $display("included a %0d-cycle output hold-off and a full drain pause", 200);
    if (n_bad == 0 && xform_q.size() == 0) begin
      $display("[euler_pose_to_homogeneous_top] OK");
    end else begin
      $display("%0d mismatches, %0d words missing", n_bad, xform_q.size());
      $display("[euler_pose_to_homogeneous_top] ERROR");
    end
    $finish;
  end

endmodule
